>>> src/edcol_pkg.sv
`timescale 1ns / 1ps

package edcol_pkg;

	localparam int MAX_PATTERN_DEF  = 64;
	localparam int SYMBOL_WIDTH_DEF = 8;

	localparam int DIST_W   = 16;
	localparam int ORIG_W   = 7;
	localparam int LEN_W    = 7;
	localparam int IDX_W    = 6;
	localparam int IN_SYM_W = 8;

	typedef enum logic [1:0] {
		ACT_LOAD  = 2'd0,
		ACT_START = 2'd1,
		ACT_STEP  = 2'd2,
		ACT_MARK  = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DONE
	} state_t;

	// control that travels with the wavefront
	typedef struct packed {
		logic             tok;
		action_t          op;
		logic [IDX_W-1:0] idx;
	} ctl_t;

	// new and old values of the nearest active cell upstream
	typedef struct packed {
		logic [DIST_W-1:0] nd;
		logic [ORIG_W-1:0] no;
		logic [DIST_W-1:0] od;
		logic [ORIG_W-1:0] oo;
	} cell_dat_t;

	function automatic logic [DIST_W-1:0] sat_inc(input logic [DIST_W-1:0] d,
	                                              input logic b);
		if (d == {DIST_W{1'b1}})
			return d;
		return d + {{(DIST_W-1){1'b0}}, b};
	endfunction

endpackage

>>> src/edit_distance_column_origin_unit.sv
`timescale 1ns / 1ps
// One beat at a time: a new beat is accepted only after the last one's wavefront
// has crossed the MAX_PATTERN + 1 cells of the column, one a cycle, and its result
// has gone to the output register, so acceptance waits longer while a result stalls.
// Reset (arst_n, asynchronous, active low) clears distances, origins, length and
// control at once; pattern symbols hold no value until loaded.

module edit_distance_column_origin_unit #(
	parameter int MAX_PATTERN  = edcol_pkg::MAX_PATTERN_DEF,
	parameter int SYMBOL_WIDTH = edcol_pkg::SYMBOL_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [1:0]                      action,
	input  logic [edcol_pkg::IDX_W-1:0]     pattern_index,
	input  logic [edcol_pkg::IN_SYM_W-1:0]  symbol,
	input  logic                            cfg_we,
	input  logic [edcol_pkg::LEN_W-1:0]     cfg_data,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [edcol_pkg::DIST_W-1:0]    distance,
	output logic [edcol_pkg::ORIG_W-1:0]    origin_row
);
	import edcol_pkg::*;

	logic [LEN_W-1:0]        len;
	ctl_t                    ctl  [MAX_PATTERN+2];
	logic [SYMBOL_WIDTH-1:0] sym  [MAX_PATTERN+2];
	cell_dat_t               dat  [MAX_PATTERN+2];

	edcol_ctrl #(
		.SYMBOL_WIDTH(SYMBOL_WIDTH)
	) u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.action       (action),
		.pattern_index(pattern_index),
		.symbol       (symbol),
		.cfg_we       (cfg_we),
		.cfg_data     (cfg_data),
		.len          (len),
		.head_ctl     (ctl[0]),
		.head_sym     (sym[0]),
		.head_dat     (dat[0]),
		.tail_ctl     (ctl[MAX_PATTERN+1]),
		.tail_dat     (dat[MAX_PATTERN+1]),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.distance     (distance),
		.origin_row   (origin_row)
	);

	generate
		for (genvar r = 0; r <= MAX_PATTERN; r++) begin : g_cell
			edcol_cell #(
				.ROW         (r),
				.SYMBOL_WIDTH(SYMBOL_WIDTH)
			) u_cell (
				.clk   (clk),
				.arst_n(arst_n),
				.len   (len),
				.up_ctl(ctl[r]),
				.up_sym(sym[r]),
				.up_dat(dat[r]),
				.dn_ctl(ctl[r+1]),
				.dn_sym(sym[r+1]),
				.dn_dat(dat[r+1])
			);
		end
	endgenerate

endmodule

>>> src/edcol_cell.sv
`timescale 1ns / 1ps

module edcol_cell #(
	parameter int ROW          = 0,
	parameter int SYMBOL_WIDTH = edcol_pkg::SYMBOL_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [edcol_pkg::LEN_W-1:0]  len,
	input  edcol_pkg::ctl_t              up_ctl,
	input  logic [SYMBOL_WIDTH-1:0]      up_sym,
	input  edcol_pkg::cell_dat_t         up_dat,
	output edcol_pkg::ctl_t              dn_ctl,
	output logic [SYMBOL_WIDTH-1:0]      dn_sym,
	output edcol_pkg::cell_dat_t         dn_dat
);
	import edcol_pkg::*;

	logic [DIST_W-1:0]       dist_q;
	logic [ORIG_W-1:0]       orig_q;
	logic                    tok_q;
	action_t                 op_q;
	logic [IDX_W-1:0]        idx_q;
	logic [SYMBOL_WIDTH-1:0] sym_q;
	cell_dat_t               dat_q;

	logic              act;
	logic              cost;
	logic [DIST_W-1:0] rep, ins, del;
	logic [DIST_W-1:0] new_d;
	logic [ORIG_W-1:0] new_o;

	generate
		if (ROW > 0) begin : g_pat
			logic [SYMBOL_WIDTH-1:0] pat_q;

			always_ff @(posedge clk) begin
				if (up_ctl.tok && up_ctl.op == ACT_LOAD &&
				    (32'(up_ctl.idx) + 32'd1) == 32'(ROW))
					pat_q <= up_sym;
			end

			assign cost = (pat_q != up_sym);
		end else begin : g_nopat
			assign cost = 1'b0;
		end
	endgenerate

	always_comb begin
		act   = up_ctl.tok && (32'(ROW) <= 32'(len));
		rep   = sat_inc(up_dat.od, cost);
		ins   = sat_inc(dist_q, 1'b1);
		del   = sat_inc(up_dat.nd, 1'b1);
		new_d = dist_q;
		new_o = orig_q;
		case (up_ctl.op)
			ACT_START: begin
				new_d = DIST_W'(ROW);
				new_o = ORIG_W'(ROW);
			end
			ACT_MARK: begin
				new_o = ORIG_W'(ROW);
			end
			ACT_STEP: begin
				if (ROW == 0) begin
					new_d = ins;
				end else if (rep <= ins && rep <= del) begin
					new_d = rep;
					new_o = up_dat.oo;
				end else if (ins <= del) begin
					new_d = ins;
				end else begin
					new_d = del;
					new_o = up_dat.no;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dist_q <= '0;
			orig_q <= '0;
			tok_q  <= 1'b0;
		end else begin
			if (act) begin
				dist_q <= new_d;
				orig_q <= new_o;
			end
			tok_q <= up_ctl.tok;
		end
	end

	// hand the beat on; cells beyond the length forward the new values they receive
	always_ff @(posedge clk) begin
		op_q     <= up_ctl.op;
		idx_q    <= up_ctl.idx;
		sym_q    <= up_sym;
		dat_q.nd <= act ? new_d : up_dat.nd;
		dat_q.no <= act ? new_o : up_dat.no;
		dat_q.od <= dist_q;
		dat_q.oo <= orig_q;
	end

	assign dn_ctl = '{tok: tok_q, op: op_q, idx: idx_q};
	assign dn_sym = sym_q;
	assign dn_dat = dat_q;

endmodule

>>> src/edcol_ctrl.sv
`timescale 1ns / 1ps

module edcol_ctrl #(
	parameter int SYMBOL_WIDTH = edcol_pkg::SYMBOL_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [1:0]                      action,
	input  logic [edcol_pkg::IDX_W-1:0]     pattern_index,
	input  logic [edcol_pkg::IN_SYM_W-1:0]  symbol,
	input  logic                            cfg_we,
	input  logic [edcol_pkg::LEN_W-1:0]     cfg_data,
	output logic [edcol_pkg::LEN_W-1:0]     len,
	output edcol_pkg::ctl_t                 head_ctl,
	output logic [SYMBOL_WIDTH-1:0]         head_sym,
	output edcol_pkg::cell_dat_t            head_dat,
	input  edcol_pkg::ctl_t                 tail_ctl,
	input  edcol_pkg::cell_dat_t            tail_dat,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [edcol_pkg::DIST_W-1:0]    distance,
	output logic [edcol_pkg::ORIG_W-1:0]    origin_row
);
	import edcol_pkg::*;

	state_t                  state_q, state_d;
	logic [LEN_W-1:0]        len_q;
	logic                    head_tok_q;
	action_t                 head_op_q;
	logic [IDX_W-1:0]        head_idx_q;
	logic [SYMBOL_WIDTH-1:0] sym_q;
	logic [DIST_W-1:0]       res_d_q;
	logic [ORIG_W-1:0]       res_o_q;
	logic                    out_valid_q;
	logic [DIST_W-1:0]       dist_q;
	logic [ORIG_W-1:0]       orig_q;

	logic accept;
	logic out_free;
	logic load_tail;
	logic load_res;
	logic cap_res;

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		load_tail = 1'b0;
		load_res  = 1'b0;
		cap_res   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid)
					state_d = ST_RUN;
			end
			ST_RUN: begin
				if (tail_ctl.tok) begin
					if (out_free) begin
						load_tail = 1'b1;
						state_d   = ST_IDLE;
					end else begin
						cap_res = 1'b1;
						state_d = ST_DONE;
					end
				end
			end
			ST_DONE: begin
				if (out_free) begin
					load_res = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			len_q       <= '0;
			head_tok_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			head_tok_q <= accept;
			if (cfg_we)
				len_q <= cfg_data;
			if (load_tail || load_res)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			head_op_q  <= action_t'(action);
			head_idx_q <= pattern_index;
			sym_q      <= SYMBOL_WIDTH'(symbol);
		end
		if (cap_res) begin
			res_d_q <= tail_dat.nd;
			res_o_q <= tail_dat.no;
		end
		if (load_tail) begin
			dist_q <= tail_dat.nd;
			orig_q <= tail_dat.no;
		end else if (load_res) begin
			dist_q <= res_d_q;
			orig_q <= res_o_q;
		end
	end

	assign len        = len_q;
	assign head_ctl   = '{tok: head_tok_q, op: head_op_q, idx: head_idx_q};
	assign head_sym   = sym_q;
	assign head_dat   = '0;
	assign out_valid  = out_valid_q;
	assign distance   = dist_q;
	assign origin_row = orig_q;

`ifndef SYNTHESIS
	a_tail_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		tail_ctl.tok |-> state_q == ST_RUN)
		else $error("wavefront left the chain outside a run");

	a_head_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		head_tok_q |-> state_q == ST_RUN)
		else $error("wavefront launched outside a run");

	a_done_full: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE |-> out_valid_q)
		else $error("result held back while output register is empty");

	a_accept_launch: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> head_tok_q && state_q == ST_RUN)
		else $error("accepted beat did not launch a wavefront");
`endif

endmodule

>>> verif/tb_edit_distance_column_origin_unit.sv
`timescale 1ns / 1ps

module tb_edit_distance_column_origin_unit;
	import edcol_pkg::*;

	localparam int MAX_PAT        = MAX_PATTERN_DEF;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 500;
	localparam int SETTLE_CYCLES  = MAX_PAT + 6;
	localparam int RANDOM_ITEMS   = 1820;

	typedef struct packed {
		logic [DIST_W-1:0] dst;
		logic [ORIG_W-1:0] orig;
	} last_cell_t;

	logic                clk = 1'b0;
	logic                arst_n;
	logic                in_valid;
	logic                in_ready;
	logic [1:0]          action;
	logic [IDX_W-1:0]    pattern_index;
	logic [IN_SYM_W-1:0] symbol;
	logic                cfg_we;
	logic [LEN_W-1:0]    cfg_data;
	logic                out_valid;
	logic                out_ready;
	logic [DIST_W-1:0]   distance;
	logic [ORIG_W-1:0]   origin_row;

	// own copy of the column state
	logic [IN_SYM_W-1:0] pattern_mem [MAX_PAT];
	logic [DIST_W-1:0]   dist_col [MAX_PAT+1];
	logic [ORIG_W-1:0]   orig_col [MAX_PAT+1];
	logic [LEN_W-1:0]    length_reg;

	last_cell_t pending_cells [$];
	int         mismatches = 0;
	int         idle_cycles = 0;
	int         stall_left = 0;
	bit         sender_steady = 1'b0;
	bit         receiver_steady = 1'b0;
	bit         hold_req = 1'b0;

	edit_distance_column_origin_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.action        (action),
		.pattern_index (pattern_index),
		.symbol        (symbol),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.distance      (distance),
		.origin_row    (origin_row)
	);

	always #2 clk = ~clk;

	function automatic logic [DIST_W-1:0] sat_plus(input logic [DIST_W-1:0] d, input logic inc);
		logic [DIST_W:0] s;
		s = {1'b0, d} + {{DIST_W{1'b0}}, inc};
		return s[DIST_W] ? {DIST_W{1'b1}} : s[DIST_W-1:0];
	endfunction

	function automatic last_cell_t apply_to_column(input action_t act,
	                                               input logic [IDX_W-1:0] idx,
	                                               input logic [IN_SYM_W-1:0] sym);
		int                len;
		logic [DIST_W-1:0] diag_d, old_d, rep, ins, del;
		logic [ORIG_W-1:0] diag_o, old_o;
		last_cell_t        res;
		len = (length_reg > MAX_PAT) ? MAX_PAT : int'(length_reg);
		case (act)
			ACT_LOAD: begin
				if (idx < MAX_PAT)
					pattern_mem[idx] = sym;
			end
			ACT_START: begin
				for (int r = 0; r <= len; r++) begin
					dist_col[r] = DIST_W'(r);
					orig_col[r] = ORIG_W'(r);
				end
			end
			ACT_STEP: begin
				diag_d = dist_col[0];
				diag_o = orig_col[0];
				dist_col[0] = sat_plus(dist_col[0], 1'b1);
				for (int r = 1; r <= len; r++) begin
					old_d = dist_col[r];
					old_o = orig_col[r];
					rep = sat_plus(diag_d, pattern_mem[r-1] != sym);
					ins = sat_plus(old_d, 1'b1);
					del = sat_plus(dist_col[r-1], 1'b1);
					// ties: replacement, then insertion, then deletion
					if (rep <= ins && rep <= del) begin
						dist_col[r] = rep;
						orig_col[r] = diag_o;
					end else if (ins <= del) begin
						dist_col[r] = ins;
						orig_col[r] = old_o;
					end else begin
						dist_col[r] = del;
						orig_col[r] = orig_col[r-1];
					end
					diag_d = old_d;
					diag_o = old_o;
				end
			end
			default: begin
				for (int r = 0; r <= len; r++)
					orig_col[r] = ORIG_W'(r);
			end
		endcase
		res.dst  = dist_col[len];
		res.orig = orig_col[len];
		return res;
	endfunction

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int p;
		p = $urandom_range(0, 99);
		if (p < 55)
			return 0;
		if (p < 88)
			return $urandom_range(1, 3);
		if (p < 97)
			return $urandom_range(4, 20);
		return $urandom_range(40, 150);
	endfunction

	// small alphabet most of the time so that matches and ties are common
	function automatic logic [IN_SYM_W-1:0] text_sym();
		if ($urandom_range(0, 3) != 0)
			return IN_SYM_W'(8'h41 + $urandom_range(0, 3));
		return IN_SYM_W'($urandom_range(0, 255));
	endfunction

	// called just after a falling edge; leaves valid high on return
	task automatic send_item(input action_t act, input logic [IDX_W-1:0] idx,
	                         input logic [IN_SYM_W-1:0] sym);
		int gap;
		gap = sender_steady ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid      <= 1'b1;
		action        <= act;
		pattern_index <= idx;
		symbol        <= sym;
		do @(posedge clk); while (!in_ready);
		pending_cells.push_back(apply_to_column(act, idx, sym));
		@(negedge clk);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (pending_cells.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic set_length(input logic [LEN_W-1:0] len);
		drain_results();
		cfg_we   <= 1'b1;
		cfg_data <= len;
		@(negedge clk);
		cfg_we     <= 1'b0;
		length_reg = len;
	endtask

	task automatic test_reset_state();
		// length zero: only row 0 takes part, no pattern symbol is read
		send_item(ACT_STEP, 6'h00, 8'h00);
		send_item(ACT_MARK, 6'h3F, 8'hFF);
		send_item(ACT_STEP, 6'h2A, 8'hFF);
		send_item(ACT_START, 6'h00, 8'h00);
		send_item(ACT_STEP, 6'h15, 8'h55);
	endtask

	task automatic test_short_pattern();
		set_length(LEN_W'(4));
		send_item(ACT_LOAD, 6'd0, 8'h00);
		send_item(ACT_LOAD, 6'd1, 8'hFF);
		send_item(ACT_LOAD, 6'd2, 8'h41);
		send_item(ACT_LOAD, 6'd3, 8'h41);
		send_item(ACT_START, 6'd0, 8'h00);
		send_item(ACT_STEP, 6'd0, 8'h00);
		send_item(ACT_STEP, 6'd0, 8'hFF);
		send_item(ACT_STEP, 6'd0, 8'h41);
		send_item(ACT_MARK, 6'd0, 8'h00);
		send_item(ACT_STEP, 6'd0, 8'h41);
		send_item(ACT_STEP, 6'd0, 8'h7E);
		send_item(ACT_START, 6'd0, 8'h00);
		send_item(ACT_STEP, 6'd0, 8'h41);
	endtask

	task automatic test_length_extremes();
		// fill the rest of the pattern so any length is safe to step
		for (int i = 4; i < MAX_PAT; i++)
			send_item(ACT_LOAD, IDX_W'(i), (i == MAX_PAT - 1) ? 8'hFF : text_sym());
		set_length(LEN_W'(MAX_PAT));
		send_item(ACT_START, 6'd0, 8'h00);
		send_item(ACT_STEP, 6'd0, 8'h41);
		send_item(ACT_STEP, 6'd0, 8'h00);
		// above the maximum acts as the maximum
		set_length(LEN_W'(127));
		send_item(ACT_STEP, 6'd0, 8'hFF);
		send_item(ACT_MARK, 6'd0, 8'h00);
		send_item(ACT_STEP, 6'd0, 8'h42);
		// shrink, then grow again: cells above the short length keep their values
		set_length(LEN_W'(2));
		send_item(ACT_STEP, 6'd0, 8'h41);
		set_length(LEN_W'(10));
		send_item(ACT_STEP, 6'd0, 8'h43);
		set_length(LEN_W'(0));
		send_item(ACT_STEP, 6'd0, 8'h44);
	endtask

	task automatic test_random_traffic();
		int sent;
		int pick;
		int run;
		logic [LEN_W-1:0] len;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			pick = $urandom_range(0, 9);
			if (pick < 6)
				len = LEN_W'($urandom_range(0, 12));
			else if (pick < 8)
				len = LEN_W'($urandom_range(13, MAX_PAT));
			else if (pick == 8)
				len = $urandom_range(0, 1) ? LEN_W'(MAX_PAT) : LEN_W'(0);
			else
				len = LEN_W'($urandom_range(MAX_PAT + 1, 127));
			set_length(len);
			sender_steady   = ($urandom_range(0, 4) == 0);
			receiver_steady = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 7) != 0) begin
				send_item(ACT_START, IDX_W'($urandom), IN_SYM_W'($urandom));
				sent++;
			end
			run = $urandom_range(20, 80);
			repeat (run) begin
				pick = $urandom_range(0, 99);
				if (pick < 78)
					send_item(ACT_STEP, IDX_W'($urandom), text_sym());
				else if (pick < 86)
					send_item(ACT_LOAD, IDX_W'($urandom), text_sym());
				else if (pick < 94)
					send_item(ACT_MARK, IDX_W'($urandom), IN_SYM_W'($urandom));
				else
					send_item(ACT_START, IDX_W'($urandom), IN_SYM_W'($urandom));
				sent++;
			end
		end
		sender_steady   = 1'b0;
		receiver_steady = 1'b0;
	endtask

	task automatic test_result_hold();
		set_length(LEN_W'($urandom_range(1, MAX_PAT)));
		send_item(ACT_START, 6'd0, 8'h00);
		// stall the result side while beats keep coming, so the input backs up
		hold_req      = 1'b1;
		sender_steady = 1'b1;
		repeat (40)
			send_item(ACT_STEP, IDX_W'($urandom), text_sym());
		sender_steady = 1'b0;
		// pause until every result is home, then carry on
		drain_results();
		repeat (20)
			send_item(ACT_STEP, IDX_W'($urandom), text_sym());
		drain_results();
	endtask

	always @(negedge clk) begin
		if (hold_req) begin
			hold_req   = 1'b0;
			stall_left = HOLD_CYCLES;
		end
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else if (!receiver_steady && $urandom_range(0, 3) == 0) begin
			stall_left = pick_gap();
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		last_cell_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_cells.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("result beat with nothing pending: distance %0d origin_row %0d",
					         distance, origin_row);
			end else begin
				want = pending_cells.pop_front();
				if (distance !== want.dst || origin_row !== want.orig) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: distance exp %0d got %0d, origin_row exp %0d got %0d",
						         want.dst, distance, want.orig, origin_row);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		in_valid      = 1'b0;
		action        = ACT_LOAD;
		pattern_index = '0;
		symbol        = '0;
		cfg_we        = 1'b0;
		cfg_data      = '0;
		out_ready     = 1'b0;
		arst_n        = 1'b0;
		length_reg    = '0;
		for (int r = 0; r <= MAX_PAT; r++) begin
			dist_col[r] = '0;
			orig_col[r] = '0;
		end
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		test_reset_state();
		test_short_pattern();
		test_length_extremes();
		test_random_traffic();
		test_result_hold();

		if (mismatches == 0 && pending_cells.size() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
